// ----- src/lane_shuffle_xorshift_scrambler_macros.svh -----
// assertion macros used by the scrambler rtl
`ifndef LANE_SHUFFLE_XORSHIFT_SCRAMBLER_MACROS_SVH
`define LANE_SHUFFLE_XORSHIFT_SCRAMBLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LSX_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsx check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define LSX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsx check failed: next-cycle implication");

`endif

// ----- src/lsx_pkg.sv -----
// shared constants and the xorshift32 step for the lane shuffle scrambler
`timescale 1ns / 1ps
`default_nettype none

package lsx_pkg;

   localparam int LANE_COUNT_DEF = 16;
   localparam int WORD_W         = 32;

   localparam logic [WORD_W-1:0] SEED_RESET   = 32'h6D2B_79F5;
   localparam logic [WORD_W-1:0] SHUFFLE_SALT = 32'hC6EF_3720;
   localparam logic [WORD_W-1:0] STREAM_SALT  = 32'h9E37_79B9;

   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   // one xorshift32 step
   function automatic logic [WORD_W-1:0] xs32(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] t;
      t = s ^ (s << XS_SHIFT_A);
      t = t ^ (t >> XS_SHIFT_B);
      t = t ^ (t << XS_SHIFT_C);
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- src/lsx_mod_unit.sv -----
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module lsx_mod_unit #(
   parameter int DIV_W = 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [lsx_pkg::WORD_W-1:0]   dividend,
   input  wire logic [DIV_W-1:0]             divisor,
   output logic                              done,
   output logic [DIV_W-1:0]                  remainder
);

   localparam int CNT_W = $clog2(lsx_pkg::WORD_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [lsx_pkg::WORD_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]            rem_ff, rem_in;
   logic [DIV_W:0]              trial;
   logic [DIV_W:0]              trial_sub;

   // restoring step: shift in next dividend bit, subtract when it fits
   always_comb begin
      trial     = {rem_ff, quo_ff[lsx_pkg::WORD_W-1]};
      trial_sub = trial - {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         rem_in = (trial >= {1'b0, divisor}) ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(lsx_pkg::WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- src/lane_shuffle_xorshift_scrambler.sv -----
// lane shuffle xorshift scrambler: sequencer, lane map and block buffer
//
//  port group | direction | handshake            | payload
//  req_       | in        | req_valid / req_stall | req_raw_byte, req_last
//  rsp_       | out       | rsp_valid / rsp_stall | rsp_out_byte, rsp_block_end, rsp_record_end
//  csr_       | in        | csr_wr_en             | csr_wr_data (seed)
//
// the first request of a record builds the lane map: an identity fill of LANE_COUNT entries,
// then LANE_COUNT-1 swaps, each waiting on the 32-step remainder unit for its index.
// every other request is only buffered; a block flush reads the map entries in order
// and emits one byte per entry inside the block, holding while rsp_stall is high.
// req_stall is high from acceptance until the last response of that request is taken.
// reset is synchronous and active high; the seed returns to its default value.
`timescale 1ns / 1ps
`default_nettype none
`include "lane_shuffle_xorshift_scrambler_macros.svh"

module lane_shuffle_xorshift_scrambler #(
   parameter int LANE_COUNT = lsx_pkg::LANE_COUNT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_raw_byte,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_block_end,
   output logic                             rsp_record_end,
   input  wire logic                        csr_wr_en,
   input  wire logic [lsx_pkg::WORD_W-1:0]  csr_wr_data
);

   localparam int LW = $clog2(LANE_COUNT);
   localparam int CW = LW + 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INIT     = 4'd1;
   localparam logic [3:0] S_SHUF_XS  = 4'd2;
   localparam logic [3:0] S_SHUF_DIV = 4'd3;
   localparam logic [3:0] S_RD_J     = 4'd4;
   localparam logic [3:0] S_RD_I     = 4'd5;
   localparam logic [3:0] S_WR_I     = 4'd6;
   localparam logic [3:0] S_WR_J     = 4'd7;
   localparam logic [3:0] S_STORE    = 4'd8;
   localparam logic [3:0] S_EM_MAP   = 4'd9;
   localparam logic [3:0] S_EM_BUF   = 4'd10;
   localparam logic [3:0] S_EM_OUT   = 4'd11;

   logic [3:0]                 state_ff, state_in;
   logic [lsx_pkg::WORD_W-1:0] seed_ff;
   logic                       in_record_ff, in_record_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [lsx_pkg::WORD_W-1:0] ks_ff, ks_in;
   logic [lsx_pkg::WORD_W-1:0] shuf_ff, shuf_in;
   logic [LW-1:0]              i_ff, i_in;
   logic [LW-1:0]              j_ff, j_in;
   logic [LW-1:0]              k_ff, k_in;
   logic [CW-1:0]              n_ff, n_in;
   logic [LW-1:0]              tj_ff, tj_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;

   // lane map and block buffer storage
   logic [LW-1:0]              perm_mem     [LANE_COUNT];
   logic [7:0]                 block_mem    [LANE_COUNT];
   logic                       map_we, map_re;
   logic [LW-1:0]              map_wa, map_ra, map_wd;
   logic [LW-1:0]              map_q_ff;
   logic                       buf_we, buf_re;
   logic [LW-1:0]              buf_wa, buf_ra;
   logic [7:0]                 buf_q_ff;

   logic                       mod_start, mod_done;
   logic [lsx_pkg::WORD_W-1:0] shuf_next;
   logic [CW-1:0]              mod_divisor;
   logic [CW-1:0]              mod_rem;
   logic [CW-1:0]              fill_inc;
   logic                       emit_last;

   // remainder unit for the shuffle index
   lsx_mod_unit #(
      .DIV_W (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (shuf_next),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign shuf_next   = lsx_pkg::xs32(shuf_ff);
   assign mod_divisor = {1'b0, i_ff} + CW'(1);
   assign fill_inc    = fill_ff + CW'(1);
   assign emit_last   = (n_ff + CW'(1)) == fill_ff;

   // seed register
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= lsx_pkg::SEED_RESET;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      in_record_in = in_record_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      ks_in        = ks_ff;
      shuf_in      = shuf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      tj_in        = tj_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      map_we       = 1'b0;
      map_re       = 1'b0;
      map_wa       = i_ff;
      map_ra       = k_ff;
      map_wd       = tj_ff;
      buf_we       = 1'b0;
      buf_re       = 1'b0;
      buf_wa       = fill_ff[LW-1:0];
      buf_ra       = map_q_ff;
      mod_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_raw_byte;
               last_in = req_last;
               if (!in_record_ff) begin
                  shuf_in      = seed_ff ^ lsx_pkg::SHUFFLE_SALT;
                  ks_in        = seed_ff ^ lsx_pkg::STREAM_SALT;
                  phase_in     = 2'd0;
                  fill_in      = '0;
                  in_record_in = 1'b1;
                  i_in         = '0;
                  state_in     = S_INIT;
               end else begin
                  state_in = S_STORE;
               end
            end
         end
         // identity fill, i_ff walks the entries
         S_INIT: begin
            map_we = 1'b1;
            map_wa = i_ff;
            map_wd = i_ff;
            if (i_ff == LW'(LANE_COUNT - 1)) begin
               state_in = S_SHUF_XS;
            end else begin
               i_in = i_ff + LW'(1);
            end
         end
         S_SHUF_XS: begin
            shuf_in   = shuf_next;
            mod_start = 1'b1;
            state_in  = S_SHUF_DIV;
         end
         S_SHUF_DIV: begin
            if (mod_done) begin
               j_in     = mod_rem[LW-1:0];
               state_in = S_RD_J;
            end
         end
         S_RD_J: begin
            map_re   = 1'b1;
            map_ra   = j_ff;
            state_in = S_RD_I;
         end
         S_RD_I: begin
            map_re   = 1'b1;
            map_ra   = i_ff;
            tj_in    = map_q_ff;
            state_in = S_WR_I;
         end
         S_WR_I: begin
            map_we   = 1'b1;
            map_wa   = i_ff;
            map_wd   = tj_ff;
            state_in = S_WR_J;
         end
         S_WR_J: begin
            map_we = 1'b1;
            map_wa = j_ff;
            map_wd = map_q_ff;
            i_in   = i_ff - LW'(1);
            if (i_ff == LW'(1)) begin
               state_in = S_STORE;
            end else begin
               state_in = S_SHUF_XS;
            end
         end
         // buffer the request byte, flush on a full block or record end
         S_STORE: begin
            buf_we  = 1'b1;
            buf_wa  = fill_ff[LW-1:0];
            fill_in = fill_inc;
            if (fill_inc == CW'(LANE_COUNT) || last_ff) begin
               k_in     = '0;
               n_in     = '0;
               state_in = S_EM_MAP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EM_MAP: begin
            map_re   = 1'b1;
            map_ra   = k_ff;
            state_in = S_EM_BUF;
         end
         // skip lanes beyond the block size
         S_EM_BUF: begin
            if ({1'b0, map_q_ff} < fill_ff) begin
               buf_re = 1'b1;
               buf_ra = map_q_ff;
               if (phase_ff == 2'd0) begin
                  ks_in = lsx_pkg::xs32(ks_ff);
               end
               state_in = S_EM_OUT;
            end else begin
               k_in     = k_ff + LW'(1);
               state_in = S_EM_MAP;
            end
         end
         S_EM_OUT: begin
            if (!rsp_stall) begin
               phase_in = phase_ff + 2'd1;
               n_in     = n_ff + CW'(1);
               k_in     = k_ff + LW'(1);
               if (emit_last) begin
                  fill_in  = '0;
                  state_in = S_IDLE;
                  if (last_ff) begin
                     in_record_in = 1'b0;
                     phase_in     = 2'd0;
                  end
               end else begin
                  state_in = S_EM_MAP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_record_ff <= 1'b0;
         fill_ff      <= '0;
         phase_ff     <= 2'd0;
         ks_ff        <= '0;
         shuf_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         in_record_ff <= in_record_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         ks_ff        <= ks_in;
         shuf_ff      <= shuf_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      n_ff    <= n_in;
      tj_ff   <= tj_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   // lane map memory, registered read
   always_ff @(posedge clock) begin
      if (map_we) begin
         perm_mem[map_wa] <= map_wd;
      end
      if (map_re) begin
         map_q_ff <= perm_mem[map_ra];
      end
   end

   // block buffer memory, registered read
   always_ff @(posedge clock) begin
      if (buf_we) begin
         block_mem[buf_wa] <= byte_ff;
      end
      if (buf_re) begin
         buf_q_ff <= block_mem[buf_ra];
      end
   end

   // response outputs
   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_EM_OUT);
   assign rsp_out_byte   = buf_q_ff ^ ks_ff[{phase_ff, 3'b000} +: 8];
   assign rsp_block_end  = emit_last;
   assign rsp_record_end = emit_last & last_ff;

   // checks
   `LSX_ASSERT_NOW(a_no_accept_while_emitting, clock, reset, rsp_valid, req_stall)
   `LSX_ASSERT_NOW(a_fill_in_range, clock, reset, 1'b1, fill_ff <= CW'(LANE_COUNT))
   `LSX_ASSERT_NEXT(a_record_closes, clock, reset, rsp_valid && !rsp_stall && rsp_record_end, !in_record_ff && !req_stall)
   `LSX_ASSERT_NEXT(a_record_opens, clock, reset, req_valid && !req_stall, in_record_ff)

endmodule

`default_nettype wire
